// ===== rtl/cnlc_pkg.sv =====
// ---------------------------------------------------------------------------
// cnlc_pkg
// shared widths and codes for the card number luhn classifier
// ---------------------------------------------------------------------------
`default_nettype none

package cnlc_pkg;

    localparam int CARD_W    = 63;
    localparam int DIGITS    = 19;
    localparam int BCD_W     = 4 * DIGITS;
    localparam int DAB_BITS  = 3;
    localparam int DAB_STEPS = (CARD_W + DAB_BITS - 1) / DAB_BITS;
    localparam int CNT_W     = 5;

    localparam logic [1:0] BRAND_INVALID    = 2'd0;
    localparam logic [1:0] BRAND_VISA       = 2'd1;
    localparam logic [1:0] BRAND_AMEX       = 2'd2;
    localparam logic [1:0] BRAND_MASTERCARD = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/card_number_luhn_classifier_top.sv =====
// ---------------------------------------------------------------------------
// card_number_luhn_classifier_top
// luhn mod-10 check, digit count and brand of a binary card number
// ---------------------------------------------------------------------------
// input channel: in_valid / in_stall with card_number, one beat per check.
// output channel: out_valid / out_stall with checksum_ok, brand and
// digit_count, one beat per input beat, in order.
// an accepted number is turned into 19 bcd digits by a shift-add-3 unit
// taking 3 bits a cycle, then the digits are scanned one a cycle, lowest
// first, for the luhn sum, digit count and lead digits, then the result
// is loaded into the output register. in_stall is high while the
// sequencer is busy, from after the input beat until that load, so a new
// number is only taken once the last one is finished.
// the output register holds a finished beat while out_stall is high and
// the next number is still accepted and converted meanwhile; a new result
// waits in its last step until the output register is free.
// reset empties the output register and returns the sequencer to idle.
// ---------------------------------------------------------------------------
`default_nettype none

module card_number_luhn_classifier_top
    import cnlc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CARD_W-1:0] card_number,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              checksum_ok,
    output logic [1:0]        brand,
    output logic [CNT_W-1:0]  digit_count
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SCAN,
        ST_EMIT
    } state_t;

    localparam logic [CNT_W-1:0] LEN_13 = 5'd13;
    localparam logic [CNT_W-1:0] LEN_15 = 5'd15;
    localparam logic [CNT_W-1:0] LEN_16 = 5'd16;
    localparam logic [CNT_W-1:0] CONV_LAST = CNT_W'(DAB_STEPS - 1);
    localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(DIGITS - 1);

    state_t             state_reg, state_next;
    logic [CARD_W-1:0]  bin_reg, bin_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [CNT_W-1:0]   step_reg, step_next;
    logic               odd_reg, odd_next;
    logic [3:0]         sum_reg, sum_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [3:0]         lead_hi_reg, lead_hi_next;
    logic [3:0]         lead_lo_reg, lead_lo_next;
    logic [3:0]         prev_reg, prev_next;
    logic               out_valid_reg, out_valid_next;
    logic               ok_reg, ok_next;
    logic [1:0]         brand_reg, brand_next;
    logic [CNT_W-1:0]   dcount_reg, dcount_next;

    logic [BCD_W-1:0]   bcd_step;
    logic [3:0]         digit;
    logic [4:0]         doubled;
    logic [3:0]         luhn_val;
    logic [4:0]         sum_raw;
    logic               ok_calc;
    logic [1:0]         brand_calc;

    cnlc_dabble_step u_dabble
    (
        .bcd_in  (bcd_reg),
        .bits    (bin_reg[CARD_W-1 -: DAB_BITS]),
        .bcd_out (bcd_step)
    );

    // luhn digit value and running sum before the mod-10 reduction
    always_comb
    begin
        digit   = bcd_reg[3:0];
        doubled = {digit, 1'b0};
        if (!odd_reg)
        begin
            luhn_val = digit;
        end
        else if (digit >= 4'd5)
        begin
            luhn_val = 4'(doubled - 5'd9);
        end
        else
        begin
            luhn_val = doubled[3:0];
        end
        sum_raw = {1'b0, sum_reg} + {1'b0, luhn_val};
    end

    // brand from checksum, length and lead digits
    always_comb
    begin
        ok_calc = (sum_reg == 4'd0);
        priority if (!ok_calc)
        begin
            brand_calc = BRAND_INVALID;
        end
        else if (count_reg == LEN_13 && lead_hi_reg == 4'd4)
        begin
            brand_calc = BRAND_VISA;
        end
        else if (count_reg == LEN_15 && lead_hi_reg == 4'd3
                 && (lead_lo_reg == 4'd4 || lead_lo_reg == 4'd7))
        begin
            brand_calc = BRAND_AMEX;
        end
        else if (count_reg == LEN_16 && lead_hi_reg == 4'd5
                 && lead_lo_reg >= 4'd1 && lead_lo_reg <= 4'd5)
        begin
            brand_calc = BRAND_MASTERCARD;
        end
        else if (count_reg == LEN_16 && lead_hi_reg == 4'd4)
        begin
            brand_calc = BRAND_VISA;
        end
        else
        begin
            brand_calc = BRAND_INVALID;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        step_next      = step_reg;
        odd_next       = odd_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        lead_hi_next   = lead_hi_reg;
        lead_lo_next   = lead_lo_reg;
        prev_next      = prev_reg;
        out_valid_next = out_valid_reg;
        ok_next        = ok_reg;
        brand_next     = brand_reg;
        dcount_next    = dcount_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    bin_next     = card_number;
                    bcd_next     = '0;
                    step_next    = '0;
                    odd_next     = 1'b0;
                    sum_next     = '0;
                    count_next   = 5'd1;
                    lead_hi_next = '0;
                    lead_lo_next = '0;
                    prev_next    = '0;
                    state_next   = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                bcd_next = bcd_step;
                bin_next = bin_reg << DAB_BITS;
                if (step_reg == CONV_LAST)
                begin
                    step_next  = '0;
                    state_next = ST_SCAN;
                end
                else
                begin
                    step_next = step_reg + 5'd1;
                end
            end
            ST_SCAN:
            begin
                bcd_next = {4'd0, bcd_reg[BCD_W-1:4]};
                odd_next = !odd_reg;
                sum_next = (sum_raw >= 5'd10) ? 4'(sum_raw - 5'd10) : sum_raw[3:0];
                prev_next = digit;
                if (digit != 4'd0)
                begin
                    count_next   = step_reg + 5'd1;
                    lead_hi_next = digit;
                    lead_lo_next = prev_reg;
                end
                if (step_reg == SCAN_LAST)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    step_next = step_reg + 5'd1;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    ok_next        = ok_calc;
                    brand_next     = brand_calc;
                    dcount_next    = count_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bin_reg       <= '0;
            bcd_reg       <= '0;
            step_reg      <= '0;
            odd_reg       <= 1'b0;
            sum_reg       <= '0;
            count_reg     <= '0;
            lead_hi_reg   <= '0;
            lead_lo_reg   <= '0;
            prev_reg      <= '0;
            out_valid_reg <= 1'b0;
            ok_reg        <= 1'b0;
            brand_reg     <= BRAND_INVALID;
            dcount_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            bin_reg       <= bin_next;
            bcd_reg       <= bcd_next;
            step_reg      <= step_next;
            odd_reg       <= odd_next;
            sum_reg       <= sum_next;
            count_reg     <= count_next;
            lead_hi_reg   <= lead_hi_next;
            lead_lo_reg   <= lead_lo_next;
            prev_reg      <= prev_next;
            out_valid_reg <= out_valid_next;
            ok_reg        <= ok_next;
            brand_reg     <= brand_next;
            dcount_reg    <= dcount_next;
        end
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign checksum_ok = ok_reg;
    assign brand       = brand_reg;
    assign digit_count = dcount_reg;

    // busy right after an input beat
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken but block not busy");

    // a new output beat only comes from the emit step
    a_rise_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_EMIT))
        else $error("output beat without emit step");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (digit_count >= 5'd1 && digit_count <= 5'd19))
        else $error("digit count out of range");

    a_brand_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && brand != BRAND_INVALID |-> checksum_ok)
        else $error("brand given with failing checksum");

endmodule

`default_nettype wire

// ===== rtl/cnlc_dabble_step.sv =====
// ---------------------------------------------------------------------------
// cnlc_dabble_step
// shift-add-3 binary to bcd unit, several input bits per use
// ---------------------------------------------------------------------------
`default_nettype none

module cnlc_dabble_step
    import cnlc_pkg::*;
(
    input  logic [BCD_W-1:0]    bcd_in,
    input  logic [DAB_BITS-1:0] bits,
    output logic [BCD_W-1:0]    bcd_out
);

    logic [BCD_W-1:0] acc;

    always_comb
    begin
        acc = bcd_in;
        for (int k = DAB_BITS - 1; k >= 0; k--)
        begin
            for (int i = 0; i < DIGITS; i++)
            begin
                if (acc[4*i +: 4] >= 4'd5)
                begin
                    acc[4*i +: 4] = acc[4*i +: 4] + 4'd3;
                end
            end
            acc = {acc[BCD_W-2:0], bits[k]};
        end
        bcd_out = acc;
    end

endmodule

`default_nettype wire
